// ===== hdl/rms_pkg.sv =====
`default_nettype none

package rms_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int SAMPLE_W       = 24;
    localparam int CH_IN_W        = 3;
    localparam int WL_W           = 7;
    localparam int WL_RESET       = 15;
    localparam int MUL_W          = 32;
    localparam int STEP_W         = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_UPDATE,
        ST_NS2_LO,
        ST_NS2_HI,
        ST_S1_SQ,
        ST_DEN,
        ST_MEAN_GO,
        ST_MEAN,
        ST_VAR_GO,
        ST_VAR,
        ST_ROOT_GO,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ_NEW,
        MUL_SQ_OLD,
        MUL_NS2_LO,
        MUL_NS2_HI,
        MUL_S1_SQ,
        MUL_DEN
    } mul_sel_t;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } iter_mode_t;

    typedef struct packed {
        logic                start;
        iter_mode_t          mode;
        logic [STEP_W-1:0]   steps;
    } iter_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rms_ring.sv =====
`default_nettype none

module rms_ring #(
    parameter int DEPTH = rms_pkg::CHANNELS_DEF * rms_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [$clog2(DEPTH)-1:0]      waddr,
    input  wire logic [rms_pkg::SAMPLE_W-1:0]  wdata,
    input  wire logic [$clog2(DEPTH)-1:0]      raddr,
    output logic      [rms_pkg::SAMPLE_W-1:0]  rdata
);

    logic [rms_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/rms_mul.sv =====
`default_nettype none

module rms_mul (
    input  wire logic                          aclk,
    input  wire logic [rms_pkg::MUL_W-1:0]     a,
    input  wire logic [rms_pkg::MUL_W-1:0]     b,
    output logic      [2*rms_pkg::MUL_W-1:0]   p
);

    logic [2*rms_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hdl/rms_iter.sv =====
`default_nettype none

// Restoring divider and digit-by-digit square root sharing one subtractor.
// One quotient or root bit is produced per cycle, MSB first.
module rms_iter #(
    parameter int XW   = 60,
    parameter int DV_W = 14
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rms_pkg::iter_cmd_t cmd,
    input  wire logic [XW-1:0]      x,
    input  wire logic [DV_W-1:0]    divisor,
    output logic                    done,
    output logic [XW-1:0]           q,
    output logic [DV_W-1:0]         rem
);

    localparam int R  = XW / 2;
    localparam int RW = (DV_W > R + 1) ? DV_W : R + 1;
    localparam int SW = RW + 2;

    logic [XW-1:0]                x_reg, x_next;
    logic [XW-1:0]                q_reg, q_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [DV_W-1:0]              div_reg;
    logic [rms_pkg::STEP_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    rms_pkg::iter_mode_t          mode_reg;
    logic [SW-1:0]                op_a, op_b, diff;
    logic                         ge;

    always_comb begin
        if (mode_reg == rms_pkg::ITER_DIV) begin
            op_a   = SW'({rem_reg[DV_W-1:0], x_reg[XW-1]});
            op_b   = SW'(div_reg);
            x_next = x_reg << 1;
        end else begin
            op_a   = SW'({rem_reg[R:0], x_reg[XW-1:XW-2]});
            op_b   = SW'({q_reg[R-1:0], 2'b01});
            x_next = x_reg << 2;
        end
        diff     = op_a - op_b;
        ge       = (op_a >= op_b);
        rem_next = ge ? RW'(diff) : RW'(op_a);
        q_next   = {q_reg[XW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == rms_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg    <= x;
            q_reg    <= '0;
            rem_reg  <= '0;
            div_reg  <= divisor;
            mode_reg <= cmd.mode;
            cnt_reg  <= cmd.steps;
        end else if (busy_reg) begin
            x_reg   <= x_next;
            q_reg   <= q_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign rem  = rem_reg[DV_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/rolling_mean_stddev.sv =====
`default_nettype none

// Channel   Dir  Width           Contents
// wl_wr     in   7               window length write (clears all channels)
// s_        in   tdata 24, tuser 4  sample, {sample_missing, channel}
// m_        out  tdata 56, tuser 3  {fill, std_dev, mean}, channel_out
//
// A word with two or more samples in its window runs the mean divide, the variance
// divide and the square root on the bit-serial divider / square root unit before the
// next s_tready. An empty window skips both divides and the root, a single sample
// skips the variance and root, and a missing sample is not stored but still runs the
// sequence that its window calls for. A channel beyond CHANNELS goes straight from
// ST_IDLE to ST_OUT. Reset is synchronous and clears all channels; window
// length returns to 15. s_tready is high only between words; a finished word waits
// in the output register while the next is taken in, and ST_OUT holds while the
// output register still has a word that m_tready has not taken.
module rolling_mean_stddev #(
    parameter int CHANNELS   = rms_pkg::CHANNELS_DEF,
    parameter int WINDOW_MAX = rms_pkg::WINDOW_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wl_wr_en,
    input  wire logic [6:0]  wl_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // sample
    input  wire logic [3:0]  s_tuser,   // channel, sample_missing
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // window_mean, window_std_dev, window_fill
    output logic [2:0]       m_tuser    // channel_out
);

    localparam int SW_S   = rms_pkg::SAMPLE_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int SUM_W  = SW_S + SLOT_W;
    localparam int SQ_W   = 2 * SW_S;
    localparam int SQS_W  = SQ_W - 1 + SLOT_W;
    localparam int NUM_W  = SQS_W + FILL_W;
    localparam int DV_W   = 2 * FILL_W;
    localparam int XW     = ((NUM_W + 1) / 2) * 2;
    localparam int DEPTH  = CHANNELS * WINDOW_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int MW     = rms_pkg::MUL_W;
    localparam int WL_RST = (rms_pkg::WL_RESET > WINDOW_MAX) ? WINDOW_MAX : rms_pkg::WL_RESET;

    rms_pkg::state_t    state_reg, state_next;
    rms_pkg::mul_sel_t  mul_sel;
    rms_pkg::iter_cmd_t iter_cmd;

    logic [rms_pkg::CH_IN_W-1:0] ch_reg;
    logic [SW_S-1:0]             smp_reg;
    logic                        miss_reg;
    logic [FILL_W-1:0]           wl_reg, wl_next;

    logic [FILL_W-1:0]        fill_reg [CHANNELS];
    logic [SLOT_W-1:0]        slot_reg [CHANNELS];
    logic signed [SUM_W-1:0]  sum_reg  [CHANNELS];
    logic [SQS_W-1:0]         sq_reg   [CHANNELS];

    logic [SQ_W-1:0]    newsq_reg;
    logic [NUM_W-1:0]   acc_reg, num_reg;
    logic [DV_W-1:0]    den_reg;
    logic [SW_S-1:0]    mean_reg, sd_reg;

    logic               m_valid_reg;
    logic [2:0]         m_ch_reg;
    logic [SW_S-1:0]    m_mean_reg, m_sd_reg;
    logic [6:0]         m_fill_reg;

    logic [CH_W+2:0]          ch_wide;
    logic [CH_W-1:0]          ch_idx;
    logic                     ch_ok;
    logic [FILL_W-1:0]        cur_fill;
    logic [SLOT_W-1:0]        cur_slot, slot_eff, slot_adv;
    logic [FILL_W-1:0]        slot_inc;
    logic signed [SUM_W-1:0]  cur_sum, sum_upd;
    logic [SUM_W-1:0]         s1_u, s1_mag;
    logic [SQS_W-1:0]         cur_sq, sq_upd;
    logic                     full;
    logic [AW-1:0]            ring_addr;
    logic [SW_S-1:0]          ring_rdata, smp_mag, old_mag;
    logic [MW-1:0]            mul_a, mul_b;
    logic [2*MW-1:0]          mul_p, acc_wide;
    logic [XW-1:0]            iter_x, iter_q;
    logic [DV_W-1:0]          iter_div, iter_rem;
    logic                     iter_done;
    logic [SUM_W-1:0]         q_mean, mean_calc;
    logic                     out_free;

    assign ch_wide  = (CH_W + 3)'(ch_reg);
    assign ch_idx   = ch_wide[CH_W-1:0];
    assign ch_ok    = (32'(ch_reg) < 32'(CHANNELS));
    assign cur_fill = fill_reg[ch_idx];
    assign cur_slot = slot_reg[ch_idx];
    assign cur_sum  = sum_reg[ch_idx];
    assign cur_sq   = sq_reg[ch_idx];
    assign full     = (cur_fill >= wl_reg);
    assign slot_eff = (FILL_W'(cur_slot) >= wl_reg) ? '0 : cur_slot;
    assign slot_inc = FILL_W'(slot_eff) + 1'b1;
    assign slot_adv = (slot_inc >= wl_reg) ? '0 : SLOT_W'(slot_inc);
    assign ring_addr = AW'(ch_idx) * AW'(WINDOW_MAX) + AW'(slot_eff);

    assign smp_mag = smp_reg[SW_S-1] ? (SW_S'(0) - smp_reg) : smp_reg;
    assign old_mag = ring_rdata[SW_S-1] ? (SW_S'(0) - ring_rdata) : ring_rdata;
    assign s1_u    = cur_sum;
    assign s1_mag  = s1_u[SUM_W-1] ? (SUM_W'(0) - s1_u) : s1_u;

    // When the window is full the oldest sample leaves as the new one enters.
    assign sum_upd = cur_sum + SUM_W'($signed(smp_reg))
                   - (full ? SUM_W'($signed(ring_rdata)) : SUM_W'(0));
    assign sq_upd  = cur_sq + SQS_W'(newsq_reg)
                   - (full ? SQS_W'(mul_p) : SQS_W'(0));

    assign acc_wide = (2 * MW)'(acc_reg);
    assign q_mean   = iter_q[SUM_W-1:0];
    assign mean_calc = s1_u[SUM_W-1]
                     ? (SUM_W'(0) - (q_mean + SUM_W'(iter_rem != '0)))
                     : q_mean;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (wl_wr_data == 7'd0) begin
            wl_next = FILL_W'(1);
        end else if (32'(wl_wr_data) > 32'(WINDOW_MAX)) begin
            wl_next = FILL_W'(WINDOW_MAX);
        end else begin
            wl_next = FILL_W'(wl_wr_data);
        end
    end

    rms_ring #(.DEPTH(DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (state_reg == rms_pkg::ST_UPDATE && !miss_reg),
        .waddr (ring_addr),
        .wdata (smp_reg),
        .raddr (ring_addr),
        .rdata (ring_rdata)
    );

    rms_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    rms_iter #(.XW(XW), .DV_W(DV_W)) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iter_cmd),
        .x       (iter_x),
        .divisor (iter_div),
        .done    (iter_done),
        .q       (iter_q),
        .rem     (iter_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rms_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (32'(s_tuser[2:0]) < 32'(CHANNELS))
                               ? rms_pkg::ST_SQ_NEW : rms_pkg::ST_OUT;
                end
            end
            rms_pkg::ST_SQ_NEW:  state_next = rms_pkg::ST_SQ_OLD;
            rms_pkg::ST_SQ_OLD:  state_next = rms_pkg::ST_UPDATE;
            rms_pkg::ST_UPDATE:  state_next = rms_pkg::ST_NS2_LO;
            rms_pkg::ST_NS2_LO:  state_next = rms_pkg::ST_NS2_HI;
            rms_pkg::ST_NS2_HI:  state_next = rms_pkg::ST_S1_SQ;
            rms_pkg::ST_S1_SQ:   state_next = rms_pkg::ST_DEN;
            rms_pkg::ST_DEN:     state_next = rms_pkg::ST_MEAN_GO;
            rms_pkg::ST_MEAN_GO: begin
                state_next = (cur_fill == '0) ? rms_pkg::ST_OUT : rms_pkg::ST_MEAN;
            end
            rms_pkg::ST_MEAN: begin
                if (iter_done) begin
                    state_next = (cur_fill >= FILL_W'(2)) ? rms_pkg::ST_VAR_GO
                                                          : rms_pkg::ST_OUT;
                end
            end
            rms_pkg::ST_VAR_GO:  state_next = rms_pkg::ST_VAR;
            rms_pkg::ST_VAR: begin
                if (iter_done) begin
                    state_next = rms_pkg::ST_ROOT_GO;
                end
            end
            rms_pkg::ST_ROOT_GO: state_next = rms_pkg::ST_ROOT;
            rms_pkg::ST_ROOT: begin
                if (iter_done) begin
                    state_next = rms_pkg::ST_OUT;
                end
            end
            rms_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = rms_pkg::ST_IDLE;
                end
            end
            default: state_next = rms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_sel        = rms_pkg::MUL_NONE;
        iter_cmd.start = 1'b0;
        iter_cmd.mode  = rms_pkg::ITER_DIV;
        iter_cmd.steps = '0;
        iter_x         = '0;
        iter_div       = '0;
        case (state_reg)
            rms_pkg::ST_SQ_NEW: mul_sel = rms_pkg::MUL_SQ_NEW;
            rms_pkg::ST_SQ_OLD: mul_sel = rms_pkg::MUL_SQ_OLD;
            rms_pkg::ST_NS2_LO: mul_sel = rms_pkg::MUL_NS2_LO;
            rms_pkg::ST_NS2_HI: mul_sel = rms_pkg::MUL_NS2_HI;
            rms_pkg::ST_S1_SQ:  mul_sel = rms_pkg::MUL_S1_SQ;
            rms_pkg::ST_DEN:    mul_sel = rms_pkg::MUL_DEN;
            rms_pkg::ST_MEAN_GO: begin
                iter_cmd.start = (cur_fill != '0);
                iter_cmd.steps = rms_pkg::STEP_W'(SUM_W);
                iter_x         = XW'(s1_mag) << (XW - SUM_W);
                iter_div       = DV_W'(cur_fill);
            end
            rms_pkg::ST_VAR_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.steps = rms_pkg::STEP_W'(NUM_W);
                iter_x         = XW'(num_reg) << (XW - NUM_W);
                iter_div       = den_reg;
            end
            rms_pkg::ST_ROOT_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.mode  = rms_pkg::ITER_SQRT;
                iter_cmd.steps = rms_pkg::STEP_W'(XW / 2);
                iter_x         = iter_q;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (mul_sel)
            rms_pkg::MUL_SQ_NEW: begin
                mul_a = MW'(smp_mag);
                mul_b = MW'(smp_mag);
            end
            rms_pkg::MUL_SQ_OLD: begin
                mul_a = MW'(old_mag);
                mul_b = MW'(old_mag);
            end
            rms_pkg::MUL_NS2_LO: begin
                mul_a = MW'(cur_fill);
                mul_b = cur_sq[MW-1:0];
            end
            rms_pkg::MUL_NS2_HI: begin
                mul_a = MW'(cur_fill);
                mul_b = MW'(cur_sq[SQS_W-1:MW]);
            end
            rms_pkg::MUL_S1_SQ: begin
                mul_a = MW'(s1_mag);
                mul_b = MW'(s1_mag);
            end
            rms_pkg::MUL_DEN: begin
                mul_a = MW'(cur_fill);
                mul_b = MW'(cur_fill - 1'b1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rms_pkg::ST_IDLE;
            wl_reg    <= FILL_W'(WL_RST);
        end else begin
            state_reg <= state_next;
            if (wl_wr_en) begin
                wl_reg <= wl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || wl_wr_en) begin
            for (int i = 0; i < CHANNELS; i++) begin
                fill_reg[i] <= '0;
                slot_reg[i] <= '0;
                sum_reg[i]  <= '0;
                sq_reg[i]   <= '0;
            end
        end else if (state_reg == rms_pkg::ST_UPDATE && !miss_reg) begin
            fill_reg[ch_idx] <= full ? cur_fill : cur_fill + 1'b1;
            slot_reg[ch_idx] <= slot_adv;
            sum_reg[ch_idx]  <= sum_upd;
            sq_reg[ch_idx]   <= sq_upd;
        end
    end

    // The shared multiplier's product is registered and is read in the state that follows the one setting its operands.
    always_ff @(posedge aclk) begin
        case (state_reg)
            rms_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ch_reg   <= s_tuser[2:0];
                    miss_reg <= s_tuser[3];
                    smp_reg  <= s_tdata;
                    mean_reg <= '0;
                    sd_reg   <= '0;
                end
            end
            rms_pkg::ST_SQ_OLD: newsq_reg <= mul_p[SQ_W-1:0];
            rms_pkg::ST_NS2_HI: acc_reg   <= NUM_W'(mul_p);
            rms_pkg::ST_S1_SQ: begin
                acc_reg <= acc_reg + NUM_W'({mul_p[MW-1:0], {MW{1'b0}}});
            end
            rms_pkg::ST_DEN: begin
                num_reg <= (acc_wide >= mul_p) ? NUM_W'(acc_wide - mul_p) : '0;
            end
            rms_pkg::ST_MEAN_GO: den_reg <= DV_W'(mul_p);
            rms_pkg::ST_MEAN: begin
                if (iter_done) begin
                    mean_reg <= mean_calc[SW_S-1:0];
                end
            end
            rms_pkg::ST_ROOT: begin
                if (iter_done) begin
                    sd_reg <= iter_q[SW_S-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == rms_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rms_pkg::ST_OUT && out_free) begin
            m_ch_reg   <= ch_reg;
            m_mean_reg <= mean_reg;
            m_sd_reg   <= sd_reg;
            m_fill_reg <= ch_ok ? 7'(cur_fill) : 7'd0;
        end
    end

    assign s_tready = (state_reg == rms_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_fill_reg, m_sd_reg, m_mean_reg};
    assign m_tuser  = m_ch_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in progress");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[54:48]) <= 32'(WINDOW_MAX))
        else $error("window fill beyond window depth");

    a_sd_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[54:48] < 7'd2 |-> m_tdata[47:24] == '0)
        else $error("nonzero deviation with fewer than two samples");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> state_reg == rms_pkg::ST_MEAN || state_reg == rms_pkg::ST_VAR
                      || state_reg == rms_pkg::ST_ROOT)
        else $error("divide or root finished outside a wait state");

endmodule

`default_nettype wire
